/* hdl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative cache LRU simulator:
// access modes, configuration register indexes, field widths and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

   // Access kinds carried in a request.
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;
   localparam logic [MODE_W-1:0] MODE_INSTR  = 2'd3;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS        = 2'd2;

   localparam int SET_BITS_W = 3;
   localparam int OFF_BITS_W = 5;
   localparam int WAYS_W     = 4;

   localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 3'd4;
   localparam logic [OFF_BITS_W-1:0] OFF_BITS_RST = 5'd4;
   localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

   // Result fields.
   localparam int HIT_W = 2;
   localparam int CNT_W = 32;

   typedef struct packed {
      logic load;     // capture the request and split its address
      logic read;     // read the set row from the tag store
      logic update;   // resolve the access, write back, load the result
   } sacl_cmd_type;

endpackage

`default_nettype wire

/* hdl/sacl_ram.sv */
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/sacl_ctrl.sv */
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer of the cache simulator: takes a request, steps the datapath
// through set read and update, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      sacl_pkg::sacl_cmd_type cmd
);
   import sacl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // The output register may be reloaded once its result is gone or leaving.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hdl/sacl_datapath.sv */
// ----------------------------------------------------------------------------
// sacl_datapath
// Configuration registers, address split, tag store with per-set row valid
// bits, parallel tag compare, victim choice, LRU rank update and the
// saturating totals.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_datapath #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_BITS    = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sacl_pkg::sacl_cmd_type           cmd,
   input  wire logic                             csr_we,
   input  wire logic [sacl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sacl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [sacl_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [ADDR_BITS-1:0]             req_address,
   output      logic [sacl_pkg::HIT_W-1:0]       rsp_hit_count,
   output      logic                             rsp_missed,
   output      logic                             rsp_evicted,
   output      logic [sacl_pkg::CNT_W-1:0]       rsp_total_hits,
   output      logic [sacl_pkg::CNT_W-1:0]       rsp_total_misses,
   output      logic [sacl_pkg::CNT_W-1:0]       rsp_total_evictions
);
   import sacl_pkg::*;

   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int SH_W     = OFF_BITS_W + 1;
   localparam int TAG_BASE = MAX_WAYS;
   localparam int RANK_BASE = MAX_WAYS * (1 + ADDR_BITS);
   localparam int ROW_W    = MAX_WAYS * (1 + ADDR_BITS + RANK_W);
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

   // Configuration.
   logic [SET_BITS_W-1:0] set_bits_ff;
   logic [OFF_BITS_W-1:0] off_bits_ff;
   logic [WAYS_W-1:0]     ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff <= SET_BITS_RST;
         off_bits_ff <= OFF_BITS_RST;
         ways_ff     <= WAYS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS:    set_bits_ff <= csr_wdata[SET_BITS_W-1:0];
            CSR_OFFSET_BITS: off_bits_ff <= csr_wdata[OFF_BITS_W-1:0];
            CSR_WAYS:        ways_ff     <= csr_wdata[WAYS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Address split.
   logic [SET_BITS_W-1:0] s_eff;
   logic [SET_W-1:0]      set_mask;
   logic [ADDR_BITS-1:0]  off_shifted;
   logic [SET_W-1:0]      set_in;
   logic [ADDR_BITS-1:0]  tag_in;
   logic [MAX_WAYS-1:0]   in_use;
   int                    ways_eff;

   always_comb begin
      s_eff = (int'(set_bits_ff) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_ff;
      for (int j = 0; j < SET_W; j++) begin
         set_mask[j] = (j < int'(s_eff));
      end
      off_shifted = req_address >> off_bits_ff;
      set_in      = off_shifted[SET_W-1:0] & set_mask;
      tag_in      = req_address >> (SH_W'(off_bits_ff) + SH_W'(s_eff));
      if (ways_ff == '0) begin
         ways_eff = 1;
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = MAX_WAYS;
      end else begin
         ways_eff = int'(ways_ff);
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         in_use[i] = (i < ways_eff);
      end
   end

   logic [MODE_W-1:0]    mode_ff;
   logic [SET_W-1:0]     set_ff;
   logic [ADDR_BITS-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         set_ff  <= set_in;
         tag_ff  <= tag_in;
      end
   end

   // Tag store: one row per set. A row never written reads as all invalid,
   // all ranks zero, through its row valid bit.
   logic [NUM_SETS-1:0] row_valid_ff;
   logic                row_ok_ff;
   logic [ROW_W-1:0]    rd_row;
   logic [ROW_W-1:0]    wr_row;
   logic                wr_en;

   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (set_ff),
      .wr_data (wr_row),
      .rd_en   (cmd.read),
      .rd_addr (set_ff),
      .rd_data (rd_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[set_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         row_ok_ff <= row_valid_ff[set_ff];
      end
   end

   // Access resolution.
   logic [MAX_WAYS-1:0]  way_v;
   logic [ADDR_BITS-1:0] way_tag  [MAX_WAYS];
   logic [RANK_W-1:0]    way_rank [MAX_WAYS];
   logic [RANK_W-1:0]    new_rank [MAX_WAYS];
   logic [MAX_WAYS-1:0]  hit_vec;
   logic [MAX_WAYS-1:0]  inv_vec;
   logic                 hit;
   logic                 has_inv;
   int                   hit_way;
   int                   fill_way;
   int                   victim;
   int                   acc_way;
   logic [RANK_W-1:0]    best;
   logic [RANK_W-1:0]    old_rank;
   logic                 old_all;
   logic                 evict;
   logic                 is_modify;
   logic                 active;
   logic [HIT_W-1:0]     hits_inc;

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         way_v[i]    = row_ok_ff & rd_row[i];
         way_tag[i]  = rd_row[TAG_BASE + i*ADDR_BITS +: ADDR_BITS];
         way_rank[i] = row_ok_ff ? rd_row[RANK_BASE + i*RANK_W +: RANK_W] : '0;
         hit_vec[i]  = in_use[i] & way_v[i] & (way_tag[i] == tag_ff);
         inv_vec[i]  = in_use[i] & ~way_v[i];
      end
      hit     = |hit_vec;
      has_inv = |inv_vec;

      // Lowest matching way and lowest free way.
      hit_way  = 0;
      fill_way = 0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) hit_way = i;
         if (inv_vec[i]) fill_way = i;
      end

      // Oldest way in use; ties keep the lower way.
      victim = 0;
      best   = way_rank[0];
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (in_use[i] && (way_rank[i] > best)) begin
            best   = way_rank[i];
            victim = i;
         end
      end

      if (hit) begin
         acc_way = hit_way;
      end else if (has_inv) begin
         acc_way = fill_way;
      end else begin
         acc_way = victim;
      end
      old_rank = hit ? way_rank[hit_way] : best;
      // A fill is older than every line, so all valid ways age.
      old_all  = !hit && has_inv;
      evict    = !hit && !has_inv;

      wr_row = rd_row;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (i == acc_way) begin
            new_rank[i] = '0;
         end else if (in_use[i] && way_v[i] && (old_all || (way_rank[i] < old_rank))) begin
            new_rank[i] = (way_rank[i] == RANK_MAX) ? way_rank[i] : way_rank[i] + 1'b1;
         end else begin
            new_rank[i] = way_rank[i];
         end
         wr_row[i] = way_v[i] | (i == acc_way);
         if ((i == acc_way) && !hit) begin
            wr_row[TAG_BASE + i*ADDR_BITS +: ADDR_BITS] = tag_ff;
         end
         wr_row[RANK_BASE + i*RANK_W +: RANK_W] = new_rank[i];
      end

      active    = (mode_ff != MODE_INSTR);
      is_modify = (mode_ff == MODE_MODIFY);
      wr_en     = cmd.update && active;
      // The second access of a modify always hits the line just touched,
      // which already holds rank zero, so it only adds a hit.
      hits_inc  = active ? (HIT_W'(hit) + HIT_W'(is_modify)) : '0;
   end

   // Totals and result register.
   logic [CNT_W-1:0] hits_ff;
   logic [CNT_W-1:0] misses_ff;
   logic [CNT_W-1:0] evicts_ff;
   logic [CNT_W:0]   hits_sum;
   logic [CNT_W:0]   misses_sum;
   logic [CNT_W:0]   evicts_sum;
   logic [HIT_W-1:0] hit_count_ff;
   logic             missed_ff;
   logic             evicted_ff;

   always_comb begin
      hits_sum   = {1'b0, hits_ff} + (CNT_W+1)'(hits_inc);
      misses_sum = {1'b0, misses_ff} + (CNT_W+1)'(active && !hit);
      evicts_sum = {1'b0, evicts_ff} + (CNT_W+1)'(active && evict);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else if (cmd.update) begin
         hits_ff   <= hits_sum[CNT_W]   ? '1 : hits_sum[CNT_W-1:0];
         misses_ff <= misses_sum[CNT_W] ? '1 : misses_sum[CNT_W-1:0];
         evicts_ff <= evicts_sum[CNT_W] ? '1 : evicts_sum[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         hit_count_ff <= hits_inc;
         missed_ff    <= active && !hit;
         evicted_ff   <= active && evict;
      end
   end

   // The totals change only when a new result is loaded, so they serve as
   // the result's total fields directly.
   assign rsp_hit_count       = hit_count_ff;
   assign rsp_missed          = missed_ff;
   assign rsp_evicted         = evicted_ff;
   assign rsp_total_hits      = hits_ff;
   assign rsp_total_misses    = misses_ff;
   assign rsp_total_evictions = evicts_ff;

endmodule

`default_nettype wire

/* hdl/set_assoc_cache_lru_sim.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Tag store of a configurable set-associative cache with true LRU
// replacement, driven by a stream of trace accesses.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_mode, req_address
//   rsp      out        rsp_valid / rsp_ready  hit count, flags, three totals
//   csr      in         csr_we                 csr_index, csr_wdata
//
// A request goes through capture and address split, set row read from the
// tag store RAM, then compare, LRU update and write-back into the result
// register. Modify and instruction requests go through the same steps.
// Reset is synchronous; per-set row valid flops clear the tag store, so
// there is no clearing pass.
// A waiting result does not block the next request; only the update step
// waits until the previous result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_sim #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_BITS    = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [sacl_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [ADDR_BITS-1:0]             req_address,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [sacl_pkg::HIT_W-1:0]       rsp_hit_count,
   output      logic                             rsp_missed,
   output      logic                             rsp_evicted,
   output      logic [sacl_pkg::CNT_W-1:0]       rsp_total_hits,
   output      logic [sacl_pkg::CNT_W-1:0]       rsp_total_misses,
   output      logic [sacl_pkg::CNT_W-1:0]       rsp_total_evictions,
   input  wire logic                             csr_we,
   input  wire logic [sacl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sacl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sacl_pkg::*;

   sacl_cmd_type cmd;

   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sacl_datapath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_mode            (req_mode),
      .req_address         (req_address),
      .rsp_hit_count       (rsp_hit_count),
      .rsp_missed          (rsp_missed),
      .rsp_evicted         (rsp_evicted),
      .rsp_total_hits      (rsp_total_hits),
      .rsp_total_misses    (rsp_total_misses),
      .rsp_total_evictions (rsp_total_evictions)
   );

endmodule

`default_nettype wire

/* hdl/sacl_checker.sv */
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of the cache simulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [sacl_pkg::HIT_W-1:0]       rsp_hit_count,
   input wire logic                             rsp_missed,
   input wire logic                             rsp_evicted,
   input wire logic [sacl_pkg::CNT_W-1:0]       rsp_total_hits,
   input wire logic [sacl_pkg::CNT_W-1:0]       rsp_total_misses,
   input wire logic [sacl_pkg::CNT_W-1:0]       rsp_total_evictions
);
   import sacl_pkg::*;

   // A held result keeps its valid and its totals.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_hits)
         && $stable(rsp_total_misses) && $stable(rsp_total_evictions))
      else $error("result changed while stalled");

   // Once a request is taken, the next one is not taken back to back.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in back-to-back cycles");

   // An eviction only comes with a miss.
   a_evict_needs_miss : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_missed)
      else $error("eviction without miss");

   // After a miss only the second access of a modify can hit.
   a_miss_hit_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_missed |-> !rsp_hit_count[1] && (rsp_total_misses != '0))
      else $error("miss result inconsistent");

   // Hit totals cannot fall while no reset occurs.
   a_hits_monotonic : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid |-> rsp_total_hits >= $past(rsp_total_hits))
      else $error("hit total decreased");

endmodule

bind set_assoc_cache_lru_sim sacl_checker u_sacl_checker (.*);

`default_nettype wire
